// File: rtl/assert_macros.svh
// Assertion helpers, sampled on the rising edge, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define PMA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define PMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pma_pkg.sv
`timescale 1ns / 1ps

package pma_pkg;

    localparam int FRAC_BITS = 24;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 48;
    localparam int PROD_W    = 64;

    // square root: radicand is variance << FRAC_BITS, padded to an even width
    localparam int RAD_W      = DATA_W + FRAC_BITS + (FRAC_BITS % 2);
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SQRT_REM_W = ROOT_W + 2;
    localparam int SQRT_STEPS = ROOT_W;

    // divider: numerator is |return| << FRAC_BITS
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int DIV_REM_W = ROOT_W + 1;
    localparam int DIV_STEPS = NUM_W;

    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int ADDR_W = 4;

    localparam logic [1:0] REG_RETURNS_GIVEN = 2'd0;
    localparam logic [1:0] REG_VOLS_GIVEN    = 2'd1;
    localparam logic [1:0] REG_CURRENT_GIVEN = 2'd2;

    localparam logic signed [PROD_W-1:0] ACC_MAX_P =
        {{(PROD_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
    localparam logic signed [PROD_W-1:0] ACC_MIN_P =
        {{(PROD_W - ACC_W + 1){1'b1}}, {(ACC_W - 1){1'b0}}};
    localparam logic signed [PROD_W-1:0] OUT_MAX_P =
        {{(PROD_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [PROD_W-1:0] OUT_MIN_P =
        {{(PROD_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};
    localparam logic signed [ACC_W:0] OUT_MAX_A =
        {{(ACC_W - DATA_W + 2){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [ACC_W:0] OUT_MIN_A =
        {{(ACC_W - DATA_W + 2){1'b1}}, {(DATA_W - 1){1'b0}}};
    localparam logic signed [ACC_W:0] ONE_A =
        {{(ACC_W - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_MAX_A =
        {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN_A =
        {1'b1, {(ACC_W - 1){1'b0}}};

    typedef struct packed {
        logic returns_given;
        logic vols_given;
        logic current_given;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic fin;
    } status_t;

    function automatic logic signed [ACC_W-1:0] acc_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] add
    );
        logic signed [PROD_W-1:0] add_c;
        logic signed [ACC_W:0]    sum;
        logic signed [ACC_W-1:0]  res;
        if (add > ACC_MAX_P)
            add_c = ACC_MAX_P;
        else if (add < ACC_MIN_P)
            add_c = ACC_MIN_P;
        else
            add_c = add;
        sum = {acc[ACC_W-1], acc} + add_c[ACC_W:0];
        if (sum[ACC_W] != sum[ACC_W-1])
            res = sum[ACC_W] ? ACC_MIN_A : ACC_MAX_A;
        else
            res = sum[ACC_W-1:0];
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_acc(
        input logic signed [ACC_W:0] x
    );
        logic signed [DATA_W-1:0] res;
        if (x > OUT_MAX_A)
            res = OUT_MAX_A[DATA_W-1:0];
        else if (x < OUT_MIN_A)
            res = OUT_MIN_A[DATA_W-1:0];
        else
            res = x[DATA_W-1:0];
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_prod(
        input logic signed [PROD_W-1:0] x
    );
        logic signed [DATA_W-1:0] res;
        if (x > OUT_MAX_P)
            res = OUT_MAX_P[DATA_W-1:0];
        else if (x < OUT_MIN_P)
            res = OUT_MIN_P[DATA_W-1:0];
        else
            res = x[DATA_W-1:0];
        return res;
    endfunction

endpackage

// File: rtl/pma_ctrl.sv
`timescale 1ns / 1ps

module pma_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  pma_pkg::status_t  status,
    output pma_pkg::cmd_t     cmd
);

    typedef enum logic [6:0] {
        ST_RUN   = 7'b0000001,
        ST_DRAIN = 7'b0000010,
        ST_PREP  = 7'b0000100,
        ST_SQRT  = 7'b0001000,
        ST_DPREP = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_LOAD  = 7'b1000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [pma_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        in_ready       = (state_reg == ST_RUN);
        unique case (state_reg)
            ST_RUN:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (in_last)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.fin)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == pma_pkg::CNT_W'(pma_pkg::SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DPREP;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DPREP:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == pma_pkg::CNT_W'(pma_pkg::DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/pma_datapath.sv
`timescale 1ns / 1ps

module pma_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  pma_pkg::cmd_t                       cmd,
    input  pma_pkg::cfg_t                       cfg,
    input  logic                                last,
    input  logic signed [pma_pkg::DATA_W-1:0]   weight,
    input  logic signed [pma_pkg::DATA_W-1:0]   exp_return,
    input  logic signed [pma_pkg::DATA_W-1:0]   volatility,
    input  logic signed [pma_pkg::DATA_W-1:0]   current_weight,
    output pma_pkg::status_t                    status,
    output logic signed [pma_pkg::DATA_W-1:0]   gross_exp,
    output logic signed [pma_pkg::DATA_W-1:0]   net_exp,
    output logic signed [pma_pkg::DATA_W-1:0]   cash_frac,
    output logic signed [pma_pkg::DATA_W-1:0]   portfolio_return,
    output logic signed [pma_pkg::DATA_W-1:0]   portfolio_variance,
    output logic signed [pma_pkg::DATA_W-1:0]   portfolio_volatility,
    output logic signed [pma_pkg::DATA_W-1:0]   sharpe_ratio,
    output logic signed [pma_pkg::DATA_W-1:0]   turnover
);

    localparam int DW  = pma_pkg::DATA_W;
    localparam int AW  = pma_pkg::ACC_W;
    localparam int PW  = pma_pkg::PROD_W;
    localparam int FB  = pma_pkg::FRAC_BITS;
    localparam int RW  = pma_pkg::ROOT_W;
    localparam int RDW = pma_pkg::RAD_W;
    localparam int SRW = pma_pkg::SQRT_REM_W;
    localparam int NW  = pma_pkg::NUM_W;
    localparam int DRW = pma_pkg::DIV_REM_W;

    localparam logic [NW-1:0] Q_POS_LIM = NW'(64'h0000_0000_7FFF_FFFF);
    localparam logic [NW-1:0] Q_NEG_LIM = NW'(64'h0000_0000_8000_0000);

    // stage 1: products
    logic                 s1_valid_reg, s1_last_reg;
    logic signed [PW-1:0] s1_wr_reg, s1_wv_reg;
    logic signed [DW-1:0] s1_w_reg;
    logic [DW-1:0]        s1_absw_reg, s1_absw_next;
    logic [DW:0]          s1_absd_reg, s1_absd_next;
    logic signed [DW:0]   diff;

    // stage 2: shifted return product, squared contribution
    logic                 s2_valid_reg, s2_last_reg;
    logic signed [PW-1:0] s2_ret_reg, s2_sq_reg, s2_sq_next;
    logic signed [DW-1:0] s2_w_reg;
    logic [DW-1:0]        s2_absw_reg;
    logic [DW:0]          s2_absd_reg;
    logic signed [PW-1:0] wv_shift;
    logic signed [DW-1:0] contrib;

    // stage 3: running sums
    logic signed [AW-1:0] gross_reg, net_reg, ret_reg, var_reg, turn_reg;
    logic signed [AW-1:0] gross_next, net_next, ret_next, var_next, turn_next;
    logic signed [AW-1:0] gross_upd, net_upd, ret_upd, var_upd, turn_upd;
    logic signed [AW:0]   cash_wide;

    // end-of-portfolio snapshot
    logic signed [DW-1:0] gross_cap_reg, net_cap_reg, cash_cap_reg;
    logic signed [DW-1:0] ret_cap_reg, var_cap_reg, turn_cap_reg;

    // square root
    logic [RDW-1:0] rad_reg, rad_next;
    logic [SRW-1:0] srem_reg, srem_next, srem_sh, strial;
    logic [RW-1:0]  root_reg, root_next;

    // divider
    logic [NW-1:0]  num_reg, num_next;
    logic [DRW-1:0] drem_reg, drem_next, drem_sh, ddiv;
    logic [DW-1:0]  ret_mag;
    logic           neg_reg, neg_next;

    logic signed [DW-1:0] sharpe;

    assign diff         = {weight[DW-1], weight} - {current_weight[DW-1], current_weight};
    assign s1_absw_next = weight[DW-1] ? DW'(-weight) : DW'(weight);
    assign s1_absd_next = diff[DW] ? (DW+1)'(-diff) : (DW+1)'(diff);

    assign wv_shift   = s1_wv_reg >>> FB;
    assign contrib    = pma_pkg::sat_prod(wv_shift);
    assign s2_sq_next = contrib * contrib;

    always_comb
    begin
        gross_upd = pma_pkg::acc_add(gross_reg, {{(PW - DW){1'b0}}, s2_absw_reg});
        net_upd   = pma_pkg::acc_add(net_reg, {{(PW - DW){s2_w_reg[DW-1]}}, s2_w_reg});
        ret_upd   = pma_pkg::acc_add(ret_reg, s2_ret_reg);
        var_upd   = pma_pkg::acc_add(var_reg, s2_sq_reg >>> FB);
        turn_upd  = pma_pkg::acc_add(turn_reg, {{(PW - DW - 1){1'b0}}, s2_absd_reg});
        cash_wide = pma_pkg::ONE_A - {net_upd[AW-1], net_upd};
        gross_next = gross_reg;
        net_next   = net_reg;
        ret_next   = ret_reg;
        var_next   = var_reg;
        turn_next  = turn_reg;
        if (s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                gross_next = '0;
                net_next   = '0;
                ret_next   = '0;
                var_next   = '0;
                turn_next  = '0;
            end
            else
            begin
                gross_next = gross_upd;
                net_next   = net_upd;
                ret_next   = ret_upd;
                var_next   = var_upd;
                turn_next  = turn_upd;
            end
        end
    end

    assign status.fin = s2_valid_reg & s2_last_reg;

    // one root bit per step
    always_comb
    begin
        srem_sh   = {srem_reg[SRW-3:0], rad_reg[RDW-1 -: 2]};
        strial    = {root_reg, 2'b01};
        rad_next  = rad_reg;
        srem_next = srem_reg;
        root_next = root_reg;
        if (cmd.sqrt_init)
        begin
            rad_next  = var_cap_reg[DW-1] ? '0 : RDW'({var_cap_reg, {FB{1'b0}}});
            srem_next = '0;
            root_next = '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_next = {rad_reg[RDW-3:0], 2'b00};
            if (srem_sh >= strial)
            begin
                srem_next = srem_sh - strial;
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                srem_next = srem_sh;
                root_next = {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    // one quotient bit per step, restoring
    always_comb
    begin
        ret_mag   = ret_cap_reg[DW-1] ? DW'(-ret_cap_reg) : DW'(ret_cap_reg);
        drem_sh   = {drem_reg[DRW-2:0], num_reg[NW-1]};
        ddiv      = {1'b0, root_reg};
        num_next  = num_reg;
        drem_next = drem_reg;
        neg_next  = neg_reg;
        if (cmd.div_init)
        begin
            num_next  = {ret_mag, {FB{1'b0}}};
            drem_next = '0;
            neg_next  = ret_cap_reg[DW-1];
        end
        else if (cmd.div_step)
        begin
            if (drem_sh >= ddiv)
            begin
                drem_next = drem_sh - ddiv;
                num_next  = {num_reg[NW-2:0], 1'b1};
            end
            else
            begin
                drem_next = drem_sh;
                num_next  = {num_reg[NW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (root_reg == '0)
            sharpe = '0;
        else if (neg_reg)
            sharpe = (num_reg > Q_NEG_LIM) ? {1'b1, {(DW - 1){1'b0}}} : DW'(-num_reg);
        else
            sharpe = (num_reg > Q_POS_LIM) ? {1'b0, {(DW - 1){1'b1}}} : DW'(num_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            gross_reg    <= '0;
            net_reg      <= '0;
            ret_reg      <= '0;
            var_reg      <= '0;
            turn_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= cmd.capture;
            s2_valid_reg <= s1_valid_reg;
            gross_reg    <= gross_next;
            net_reg      <= net_next;
            ret_reg      <= ret_next;
            var_reg      <= var_next;
            turn_reg     <= turn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            s1_last_reg <= last;
            s1_wr_reg   <= weight * exp_return;
            s1_wv_reg   <= weight * volatility;
            s1_w_reg    <= weight;
            s1_absw_reg <= s1_absw_next;
            s1_absd_reg <= s1_absd_next;
        end
        if (s1_valid_reg)
        begin
            s2_last_reg <= s1_last_reg;
            s2_ret_reg  <= s1_wr_reg >>> FB;
            s2_sq_reg   <= s2_sq_next;
            s2_w_reg    <= s1_w_reg;
            s2_absw_reg <= s1_absw_reg;
            s2_absd_reg <= s1_absd_reg;
        end
        if (status.fin)
        begin
            gross_cap_reg <= pma_pkg::sat_acc({gross_upd[AW-1], gross_upd});
            net_cap_reg   <= pma_pkg::sat_acc({net_upd[AW-1], net_upd});
            cash_cap_reg  <= pma_pkg::sat_acc(cash_wide);
            ret_cap_reg   <= cfg.returns_given ?
                             pma_pkg::sat_acc({ret_upd[AW-1], ret_upd}) : '0;
            var_cap_reg   <= cfg.vols_given ?
                             pma_pkg::sat_acc({var_upd[AW-1], var_upd}) : '0;
            turn_cap_reg  <= cfg.current_given ?
                             pma_pkg::sat_acc({turn_upd[AW-1], turn_upd}) : '0;
        end
        rad_reg  <= rad_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        num_reg  <= num_next;
        drem_reg <= drem_next;
        neg_reg  <= neg_next;
        if (cmd.out_load)
        begin
            gross_exp            <= gross_cap_reg;
            net_exp              <= net_cap_reg;
            cash_frac            <= cash_cap_reg;
            portfolio_return     <= ret_cap_reg;
            portfolio_variance   <= var_cap_reg;
            portfolio_volatility <= DW'(root_reg);
            sharpe_ratio         <= sharpe;
            turnover             <= turn_cap_reg;
        end
    end

endmodule

// File: rtl/portfolio_metrics_accumulator_core.sv
// Portfolio metrics accumulator: takes one instrument per cycle (target weight,
// expected return, volatility, current weight, all Q8.24) and keeps saturating
// 48-bit sums of gross, net, return, variance and turnover. The instrument
// marked with tlast closes the portfolio; the input then stalls while the
// sums drain through the three-stage multiply pipeline, the bit-serial
// square root and the bit-serial divider for Sharpe run, and the output
// register is loaded. The result sits in an output register, so items of the
// next portfolio are accepted while it waits; a further closing item then
// holds the input off until that register is taken. Flags returns_given,
// vols_given and current_given (APB offsets 0x0, 0x4, 0x8, bit 0) zero the
// matching outputs when clear.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module portfolio_metrics_accumulator_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pma_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // instruments
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // weight, exp_return, volatility, current_weight
    input  logic [127:0]                  s_axis_tdata,
    input  logic                          s_axis_tlast,
    // results
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // gross_exp, net_exp, cash_frac, portfolio_return,
    // portfolio_variance, portfolio_volatility, sharpe_ratio, turnover
    output logic [255:0]                  m_axis_tdata
);

    localparam int DW = pma_pkg::DATA_W;

    pma_pkg::cfg_t    cfg_reg, cfg_next;
    pma_pkg::cmd_t    cmd;
    pma_pkg::status_t status;
    logic             cfg_wr;
    logic [1:0]       reg_sel;
    logic             in_close;

    logic signed [DW-1:0] gross_exp, net_exp, cash_frac, portfolio_return;
    logic signed [DW-1:0] portfolio_variance, portfolio_volatility, sharpe_ratio, turnover;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign reg_sel  = paddr[pma_pkg::ADDR_W-1:2];
    assign in_close = s_axis_tvalid & s_axis_tready & s_axis_tlast;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (reg_sel)
            pma_pkg::REG_RETURNS_GIVEN:
            begin
                prdata[0] = cfg_reg.returns_given;
                if (cfg_wr)
                    cfg_next.returns_given = pwdata[0];
            end
            pma_pkg::REG_VOLS_GIVEN:
            begin
                prdata[0] = cfg_reg.vols_given;
                if (cfg_wr)
                    cfg_next.vols_given = pwdata[0];
            end
            pma_pkg::REG_CURRENT_GIVEN:
            begin
                prdata[0] = cfg_reg.current_given;
                if (cfg_wr)
                    cfg_next.current_given = pwdata[0];
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    pma_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    pma_datapath u_datapath
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .cfg                  (cfg_reg),
        .last                 (s_axis_tlast),
        .weight               ($signed(s_axis_tdata[31:0])),
        .exp_return           ($signed(s_axis_tdata[63:32])),
        .volatility           ($signed(s_axis_tdata[95:64])),
        .current_weight       ($signed(s_axis_tdata[127:96])),
        .status               (status),
        .gross_exp            (gross_exp),
        .net_exp              (net_exp),
        .cash_frac            (cash_frac),
        .portfolio_return     (portfolio_return),
        .portfolio_variance   (portfolio_variance),
        .portfolio_volatility (portfolio_volatility),
        .sharpe_ratio         (sharpe_ratio),
        .turnover             (turnover)
    );

    assign m_axis_tdata = {turnover, sharpe_ratio, portfolio_volatility, portfolio_variance,
                           portfolio_return, cash_frac, net_exp, gross_exp};

    `PMA_ASSERT_NOW(a_fin_blocks_input, clk, rst_n, status.fin, !s_axis_tready, "item at close")
    `PMA_ASSERT_NOW(a_load_no_overwrite, clk, rst_n, cmd.out_load,
                    !m_axis_tvalid || m_axis_tready, "pending result overwritten")
    `PMA_ASSERT_NOW(a_cmd_exclusive, clk, rst_n, 1'b1, $onehot0(cmd), "commands overlap")
    `PMA_ASSERT_NEXT(a_last_stalls, clk, rst_n, in_close, !s_axis_tready, "no stall after close")

endmodule

// File: sim/portfolio_metrics_accumulator_core_tb.sv
`timescale 1ns / 1ps

module portfolio_metrics_accumulator_core_tb;

    typedef logic [7:0][31:0] metrics_t;

    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint OUT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint OUT_LO = -OUT_HI - 1;
    localparam longint UNIT   = longint'(1) << pma_pkg::FRAC_BITS;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_ONE = 32'h0100_0000;

    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 70;
    localparam int LONG_HALF    = 520;

    class portfolio_scoreboard;
        longint        gross_acc, net_acc, ret_acc, var_acc, turn_acc;
        pma_pkg::cfg_t flags;
        metrics_t      pending_metrics[$];
        int            mismatches;
        string         field_name[8] = '{"gross", "net", "cash",
                                         "portfolio_return", "portfolio_variance",
                                         "portfolio_volatility", "sharpe_ratio", "turnover"};

        function new();
            clear_sums();
            flags = '0;
            mismatches = 0;
        endfunction

        function void clear_sums();
            gross_acc = 0;
            net_acc   = 0;
            ret_acc   = 0;
            var_acc   = 0;
            turn_acc  = 0;
        endfunction

        function void set_flag(logic [1:0] idx, logic val);
            case (idx)
                pma_pkg::REG_RETURNS_GIVEN: flags.returns_given = val;
                pma_pkg::REG_VOLS_GIVEN:    flags.vols_given    = val;
                pma_pkg::REG_CURRENT_GIVEN: flags.current_given = val;
                default: ;
            endcase
        endfunction

        function longint clip(longint x, longint lo, longint hi);
            if (x < lo)
                return lo;
            if (x > hi)
                return hi;
            return x;
        endfunction

        function longint sat_add(longint acc, longint addend);
            return clip(acc + clip(addend, ACC_LO, ACC_HI), ACC_LO, ACC_HI);
        endfunction

        function longint floor_root(longint v);
            longint x, res, b;
            x = v;
            res = 0;
            b = longint'(1) << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= res + b)
                begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end
                else
                begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function void accumulate_instrument(logic signed [31:0] w, logic signed [31:0] r,
                                            logic signed [31:0] vol,
                                            logic signed [31:0] cur, logic last);
            longint   wl, rl, vl, cl, diff, contrib, ret, variance, vsd, sharpe;
            metrics_t m;
            wl = w;
            rl = r;
            vl = vol;
            cl = cur;
            diff = wl - cl;
            gross_acc = sat_add(gross_acc, (wl < 0) ? -wl : wl);
            net_acc   = sat_add(net_acc, wl);
            ret_acc   = sat_add(ret_acc, (wl * rl) >>> pma_pkg::FRAC_BITS);
            contrib   = clip((wl * vl) >>> pma_pkg::FRAC_BITS, OUT_LO, OUT_HI);
            var_acc   = sat_add(var_acc, (contrib * contrib) >>> pma_pkg::FRAC_BITS);
            turn_acc  = sat_add(turn_acc, (diff < 0) ? -diff : diff);
            if (!last)
                return;

            ret = flags.returns_given ? clip(ret_acc, OUT_LO, OUT_HI) : 0;
            variance = flags.vols_given ? clip(var_acc, OUT_LO, OUT_HI) : 0;
            vsd = 0;
            if (flags.vols_given && variance > 0)
                vsd = floor_root(variance << pma_pkg::FRAC_BITS);
            sharpe = 0;
            if (vsd > 0)
                sharpe = clip((ret * UNIT) / vsd, OUT_LO, OUT_HI);

            m[0] = 32'(clip(gross_acc, OUT_LO, OUT_HI));
            m[1] = 32'(clip(net_acc, OUT_LO, OUT_HI));
            m[2] = 32'(clip(UNIT - net_acc, OUT_LO, OUT_HI));
            m[3] = 32'(ret);
            m[4] = 32'(variance);
            m[5] = 32'(clip(vsd, OUT_LO, OUT_HI));
            m[6] = 32'(sharpe);
            m[7] = flags.current_given ? 32'(clip(turn_acc, OUT_LO, OUT_HI)) : 32'h0;
            pending_metrics = {pending_metrics, m};
            clear_sums();
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_metrics(metrics_t got);
            metrics_t want;
            if (pending_metrics.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = pending_metrics.pop_front();
            for (int k = 0; k < 8; k++)
            begin
                if (got[k] !== want[k])
                    report_mismatch($sformatf("%s got %h want %h",
                                              field_name[k], got[k], want[k]));
            end
        endtask
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [pma_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    // weight, exp_return, volatility, current_weight
    logic [127:0]               s_axis_tdata;
    logic                       s_axis_tlast;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    // gross_exp, net_exp, cash_frac, portfolio_return,
    // portfolio_variance, portfolio_volatility, sharpe_ratio, turnover
    logic [255:0]               m_axis_tdata;

    bit                  hold_req = 1'b0;
    portfolio_scoreboard sb = new();

    portfolio_metrics_accumulator_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_metrics(m_axis_tdata);
    end

    // result side back-pressure
    initial
    begin
        int  len;
        int  pick;
        logic level;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                level = 1'b0;
                len = HOLD_CYCLES;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    level = 1'b1;
                    len = $urandom_range(1, 20);
                end
                else if (pick < 95)
                begin
                    level = 1'b0;
                    len = $urandom_range(1, 3);
                end
                else
                begin
                    level = 1'b0;
                    len = $urandom_range(20, 80);
                end
            end
            m_axis_tready <= level;
            repeat (len) @(posedge clk);
        end
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [31:0] rand_field(int scale);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return int'($urandom_range(0, 1 << (scale + 1))) - (1 << scale);
        if (pick < 85)
            return $urandom;
        case ($urandom_range(0, 5))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return 32'h0;
            3:       return 32'h1;
            4:       return 32'hFFFF_FFFF;
            default: return Q_ONE;
        endcase
    endfunction

    function automatic int pick_gap(bit nogap);
        int pick;
        if (nogap)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int frame_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(13, 40);
        return $urandom_range(1, 8);
    endfunction

    task automatic send_item(logic [31:0] w, logic [31:0] r, logic [31:0] vol,
                             logic [31:0] cur, logic last, int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cur, vol, r, w};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.accumulate_instrument(w, r, vol, cur, last);
    endtask

    task automatic send_frame(int len, bit nogap);
        for (int i = 0; i < len; i++)
            send_item(rand_field(24), rand_field(23), rand_field(23), rand_field(24),
                      i == len - 1, pick_gap(nogap));
    endtask

    task automatic write_reg(logic [1:0] idx, logic val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= pma_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= {31'b0, val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_flag(idx, val);
        @(posedge clk);
    endtask

    task automatic apply_flags(pma_pkg::cfg_t c);
        write_reg(pma_pkg::REG_RETURNS_GIVEN, c.returns_given);
        write_reg(pma_pkg::REG_VOLS_GIVEN, c.vols_given);
        write_reg(pma_pkg::REG_CURRENT_GIVEN, c.current_given);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_metrics.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        pma_pkg::cfg_t phase_cfg [8];
        bit            nogap;
        int            sent;
        int            len;
        phase_cfg = '{3'b000, 3'b111, 3'b011, 3'b010, 3'b110, 3'b101, 3'b001, 3'b100};
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_flags(3'b111);
        send_item(Q_ONE, 32'h0019_999A, 32'h0033_3333, 32'h0080_0000, 1'b1, 0);
        // sums saturate high, cash low
        send_item(Q_MAX, Q_MAX, Q_MAX, Q_MIN, 1'b0, 0);
        send_item(Q_MAX, Q_MAX, Q_MAX, Q_MIN, 1'b1, 0);
        // most negative inputs
        send_item(Q_MIN, Q_MIN, Q_MIN, Q_MAX, 1'b0, 0);
        send_item(Q_MIN, Q_MIN, Q_MIN, Q_MAX, 1'b1, 0);
        send_item(32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 0);
        // zero volatility gives zero Sharpe
        send_item(Q_ONE, 32'hFF80_0000, 32'h0, 32'h0, 1'b1, 0);
        // weight-vol product clamped negative before squaring
        send_item(Q_MIN, 32'h1, Q_MAX, Q_ONE, 1'b1, 0);
        send_item(32'h1, Q_MAX, 32'h1, 32'h0, 1'b1, 0);
        // floor of small negative products
        send_item(32'hFFFF_FFFF, 32'h3, 32'hFFFF_FFFF, 32'h1, 1'b1, 0);
        // smallest nonzero variance, Sharpe saturates both ways
        send_item(Q_ONE, Q_MAX, 32'h0000_1000, Q_ONE, 1'b1, 0);
        send_item(Q_ONE, Q_MIN, 32'h0000_1000, Q_ONE, 1'b1, 0);
        send_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 0);
        send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 0);
        send_item(Q_ONE, Q_ONE, Q_ONE, 32'h0, 1'b1, 0);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            apply_flags(phase_cfg[p]);
            nogap = ($urandom_range(0, 3) == 0);
            if (p == 2)
            begin
                // output held off while closing items keep coming
                hold_req = 1'b1;
                repeat (4) send_frame(3, 1'b1);
            end
            if (p == 5)
            begin
                // return sum pinned at the 48-bit limit, then pulled back down
                for (int i = 0; i < 2 * LONG_HALF; i++)
                    send_item(Q_MIN, (i < LONG_HALF) ? Q_MIN : Q_MAX, rand_field(23),
                              rand_field(24), i == 2 * LONG_HALF - 1, 0);
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len = frame_len();
                send_frame(len, nogap);
                sent += len;
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending_metrics.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
